@@ sv/spmp_pkg.sv @@
// Shared types, constants and control word layout for the shuffled minimal standard PRNG.
package spmp_pkg;

  localparam int TABLE_SIZE   = 32;  // power of two: the table index is a bit field
  localparam int WARMUP_STEPS = 8;
  localparam int TOTAL_STEPS  = TABLE_SIZE + WARMUP_STEPS;
  localparam int IDX_W        = $clog2(TABLE_SIZE);
  localparam int CNT_W        = $clog2(TOTAL_STEPS);

  localparam int VAL_W  = 31;
  localparam int FRAC_W = 32;
  localparam int MUL_W  = 15;
  localparam int PROD_W = VAL_W + MUL_W;

  localparam logic [VAL_W-1:0]  LCG_MOD    = 31'h7FFF_FFFF;
  localparam logic [MUL_W-1:0]  LCG_MULT   = 15'd16807;
  localparam logic [VAL_W-1:0]  HALF_MOD   = 31'h3FFF_FFFF;
  localparam logic [FRAC_W-1:0] FRAC_CLAMP = 32'd4294966781;

  localparam logic [0:0] REQ_SEED = 1'b0;
  localparam logic [0:0] REQ_DRAW = 1'b1;

  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_D_MUL = 3'd1;
  localparam step_t STEP_D_FLD = 3'd2;
  localparam step_t STEP_S_LD  = 3'd3;
  localparam step_t STEP_S_MUL = 3'd4;
  localparam step_t STEP_S_FLD = 3'd5;
  localparam step_t STEP_S_SHF = 3'd6;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_CNT_NZ,
    JMP_DISPATCH
  } jmp_t;

  typedef struct packed {
    logic  take_in;   // hold here until an input item is accepted
    logic  emit;      // hold here until the output register is free
    logic  ld_seed;
    logic  mul;
    logic  fold;
    logic  fill;      // seed loop: write table at loop count below TABLE_SIZE, count down
    logic  rd_issue;  // read table at shuffle index
    logic  draw_wr;   // write new value at shuffle index, shuffle reg <= picked
    logic  set_shuf;
    jmp_t  jmp;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic seed_req;
    logic cnt_nz;
  } dp_status_t;

endpackage

@@ sv/spmp_if.sv @@
// Request and result channel interfaces.
interface spmp_req_if;
  logic                          valid;
  logic                          ready;
  logic [0:0]                    req_type;
  logic [spmp_pkg::VAL_W-1:0]    seed_value;
  modport source (output valid, req_type, seed_value, input ready);
  modport sink   (input valid, req_type, seed_value, output ready);
endinterface

interface spmp_res_if;
  logic                          valid;
  logic                          ready;
  logic [spmp_pkg::VAL_W-1:0]    random_int;
  logic [spmp_pkg::FRAC_W-1:0]   random_fraction;
  modport source (output valid, random_int, random_fraction, input ready);
  modport sink   (input valid, random_int, random_fraction, output ready);
endinterface

@@ sv/spmp_sequencer.sv @@
// Microcode sequencer: step counter, control ROM and jump logic.
module spmp_sequencer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    out_free,
  input  spmp_pkg::dp_status_t    status,
  output spmp_pkg::ctrl_t         ctrl,
  output logic                    go
);
  import spmp_pkg::*;

  step_t step;
  step_t step_next;

  function automatic ctrl_t rom(input step_t s);
    ctrl_t c;
    c = '0;
    c.jmp = JMP_NEXT;
    c.target = STEP_IDLE;
    case (s)
      STEP_IDLE: begin
        c.take_in = 1'b1;
        c.jmp = JMP_DISPATCH;
        c.target = STEP_S_LD;
      end
      STEP_D_MUL: begin
        c.mul = 1'b1;
        c.rd_issue = 1'b1;
      end
      STEP_D_FLD: begin
        c.fold = 1'b1;
        c.draw_wr = 1'b1;
        c.emit = 1'b1;
        c.jmp = JMP_GOTO;
        c.target = STEP_IDLE;
      end
      STEP_S_LD: begin
        c.ld_seed = 1'b1;
      end
      STEP_S_MUL: begin
        c.mul = 1'b1;
      end
      STEP_S_FLD: begin
        c.fold = 1'b1;
        c.fill = 1'b1;
        c.jmp = JMP_CNT_NZ;
        c.target = STEP_S_MUL;
      end
      STEP_S_SHF: begin
        c.set_shuf = 1'b1;
        c.jmp = JMP_GOTO;
        c.target = STEP_D_MUL;
      end
      default: begin
        c.jmp = JMP_GOTO;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

  assign ctrl = rom(step);
  assign go = (!ctrl.take_in || in_valid) && (!ctrl.emit || out_free);

  always_comb begin
    step_next = step_t'(step + 3'd1);
    case (ctrl.jmp)
      JMP_NEXT:     step_next = step_t'(step + 3'd1);
      JMP_GOTO:     step_next = ctrl.target;
      JMP_CNT_NZ:   if (status.cnt_nz) step_next = ctrl.target;
      JMP_DISPATCH: if (status.seed_req) step_next = ctrl.target;
      default:      step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else if (go) begin
      step <= step_next;
    end
  end

endmodule

@@ sv/spmp_datapath.sv @@
// Datapath: generator register, multiply and fold, shuffle table memory, fraction scaling.
module spmp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  spmp_pkg::ctrl_t               ctrl,
  input  logic                          go,
  input  logic [0:0]                    req_type,
  input  logic [spmp_pkg::VAL_W-1:0]    seed_value,
  output spmp_pkg::dp_status_t          status,
  output logic [spmp_pkg::VAL_W-1:0]    random_int,
  output logic [spmp_pkg::FRAC_W-1:0]   random_fraction
);
  import spmp_pkg::*;

  localparam logic [VAL_W+1:0] MOD1 = {2'b00, LCG_MOD};
  localparam logic [VAL_W+1:0] MOD2 = {1'b0, LCG_MOD, 1'b0};

  logic [VAL_W-1:0]  lcg;
  logic [VAL_W-1:0]  shuf;
  logic [VAL_W-1:0]  seed_lat;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  idx_reg;

  logic [VAL_W-1:0]  mem [TABLE_SIZE];
  logic [VAL_W-1:0]  rd_data;
  logic              we;
  logic [IDX_W-1:0]  wa;

  logic [VAL_W:0]    fold_sum;
  logic [VAL_W-1:0]  fold_val;
  logic [VAL_W-1:0]  seed_sat;
  logic              fill_hit;

  logic [VAL_W+1:0]  frac_t;
  logic [1:0]        frac_q;
  logic [VAL_W+1:0]  frac_f;

  // 2^31 == 1 mod M: add high part to low part, one conditional subtract
  assign fold_sum = {1'b0, prod[VAL_W-1:0]} + (VAL_W+1)'(prod[PROD_W-1:VAL_W]);
  assign fold_val = (fold_sum >= {1'b0, LCG_MOD}) ? VAL_W'(fold_sum - {1'b0, LCG_MOD})
                                                  : fold_sum[VAL_W-1:0];

  always_comb begin
    seed_sat = seed_lat;
    if (seed_lat == '0) seed_sat = VAL_W'(1);
    else if (seed_lat == LCG_MOD) seed_sat = LCG_MOD - VAL_W'(1);
  end

  assign fill_hit = ({1'b0, cnt} < (CNT_W+1)'(TABLE_SIZE));
  assign we = go && ((ctrl.fill && fill_hit) || ctrl.draw_wr);
  assign wa = ctrl.draw_wr ? idx_reg : cnt[IDX_W-1:0];

  assign status.seed_req = (req_type == REQ_SEED) || (shuf == '0);
  assign status.cnt_nz = (cnt != '0);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= fold_val;
    if (go && ctrl.rd_issue) rd_data <= mem[shuf[VAL_W-1 -: IDX_W]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg <= VAL_W'(1);
      shuf <= '0;
    end else if (go) begin
      if (ctrl.ld_seed) lcg <= seed_sat;
      else if (ctrl.fold) lcg <= fold_val;
      if (ctrl.set_shuf) shuf <= lcg;
      else if (ctrl.draw_wr) shuf <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (ctrl.take_in) seed_lat <= (req_type == REQ_SEED) ? seed_value : VAL_W'(1);
      if (ctrl.mul) prod <= PROD_W'(lcg) * PROD_W'(LCG_MULT);
      if (ctrl.ld_seed) cnt <= CNT_W'(TOTAL_STEPS - 1);
      else if (ctrl.fill) cnt <= cnt - CNT_W'(1);
      if (ctrl.rd_issue) idx_reg <= shuf[VAL_W-1 -: IDX_W];
    end
  end

  // v*2^32/M = 2v + 2v/M; the remaining quotient is 0, 1 or 2
  assign frac_t = {1'b0, rd_data, 1'b0} + (VAL_W+2)'(HALF_MOD);
  assign frac_q = (frac_t >= MOD2) ? 2'd2 : ((frac_t >= MOD1) ? 2'd1 : 2'd0);
  assign frac_f = {1'b0, rd_data, 1'b0} + (VAL_W+2)'(frac_q);

  assign random_int = rd_data;
  assign random_fraction = (frac_f > (VAL_W+2)'(FRAC_CLAMP)) ? FRAC_CLAMP
                                                             : frac_f[FRAC_W-1:0];

`ifndef ASSERT_OFF
  a_lcg_range: assert property (@(posedge clk) disable iff (rst)
    lcg != '0 && lcg != LCG_MOD)
    else $error("generator left its range");
  a_picked_valid: assert property (@(posedge clk) disable iff (rst)
    go && ctrl.draw_wr |-> rd_data != '0 && rd_data != LCG_MOD)
    else $error("picked entry not a generator value");
  a_seeded: assert property (@(posedge clk) disable iff (rst)
    go && ctrl.set_shuf |=> shuf != '0)
    else $error("shuffle register empty after seeding");
`endif

endmodule

@@ sv/shuffled_minimal_standard_prng.sv @@
// Top level: shuffled minimal standard PRNG with request and result channels.
//
// Usage: each item on req asks for one number. req_type 0 reseeds with
// seed_value (0 taken as 1, 2^31-1 taken as 2^31-2) and then draws;
// req_type 1 draws the next number. A draw before any seeding seeds with 1.
// Each item gives exactly one item on res: random_int (1..2^31-2) and
// random_fraction, its Q0.32 value of random_int / (2^31-1).
//
// Timing: a microcoded sequencer runs one step per cycle while it is not
// held waiting for an input item or for a free output register. A draw
// runs a multiply and table read step, then a fold step that loads the
// output register, then the idle step. A seed runs a load step, 40
// generator steps (multiply, then modular fold), a shuffle set step and
// the draw. One item is worked on at a time; the next is taken once the
// current one has reached the output register.
//
// Reset: synchronous rst returns the generator to 1 and marks it unseeded.
// Stalls: the result holds in the output register while res.ready is low;
// a following item is still accepted and runs until it needs that register.
module shuffled_minimal_standard_prng (
  input  logic        clk,
  input  logic        rst,
  spmp_req_if.sink    req,
  spmp_res_if.source  res
);
  import spmp_pkg::*;

  ctrl_t            ctrl;
  logic             go;
  dp_status_t       status;
  logic             out_free;
  logic [VAL_W-1:0]  dp_int;
  logic [FRAC_W-1:0] dp_frac;

  assign out_free = !res.valid || res.ready;
  assign req.ready = ctrl.take_in;

  spmp_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .out_free (out_free),
    .status   (status),
    .ctrl     (ctrl),
    .go       (go)
  );

  spmp_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .go              (go),
    .req_type        (req.req_type),
    .seed_value      (req.seed_value),
    .status          (status),
    .random_int      (dp_int),
    .random_fraction (dp_frac)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (go && ctrl.emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctrl.emit) begin
      res.random_int <= dp_int;
      res.random_fraction <= dp_frac;
    end
  end

endmodule
